// ===== rtl/mwsr_pkg.sv =====
// Shared constants, codes and stage structs of the wavetable sample reader.
`default_nettype none

package mwsr_pkg;

    // Field widths of one input transaction and one result transaction
    localparam int FUNC_W     = 2;
    localparam int TIDX_W     = 2;
    localparam int LEVEL_W    = 4;
    localparam int FRAME_W    = 12;
    localparam int SIDX_W     = 11;
    localparam int SAMPLE_W   = 16;
    localparam int FCNT_W     = 7;
    localparam int FLOG_W     = 4;
    localparam int PHASE_BITS = 24;
    localparam int INC_W      = PHASE_BITS + 1;

    localparam int IN_FIELDS_W  = TIDX_W + LEVEL_W + FRAME_W + SIDX_W + SAMPLE_W
                                + FCNT_W + FLOG_W + PHASE_BITS + INC_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_TUSER_W   = FUNC_W;
    localparam int OUT_FIELDS_W = SAMPLE_W + LEVEL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 1;

    // Bit length of (increment - 1), range 0..INC_W
    localparam int EXP_W = $clog2(INC_W + 1);

    // Defaults of the storage parameters
    localparam int DEF_NUM_TABLES     = 4;
    localparam int DEF_MAX_FRAMES     = 64;
    localparam int DEF_MAX_FRAME_SIZE = 2048;
    localparam int DEF_MIN_MIP_SIZE   = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_SAMPLE = 2'd0,
        FUNC_WR_DESC   = 2'd1,
        FUNC_READ      = 2'd2
    } func_t;

    typedef struct packed {
        func_t                       func;
        logic [TIDX_W-1:0]           table_index;
        logic [LEVEL_W-1:0]          level;
        logic signed [FRAME_W-1:0]   frame;
        logic [SIDX_W-1:0]           sample_index;
        logic [SAMPLE_W-1:0]         sample_value;
        logic [FCNT_W-1:0]           frame_count;
        logic [FLOG_W-1:0]           frame_size_log2;
        logic [PHASE_BITS-1:0]       phase;
        logic [INC_W-1:0]            phase_increment;
    } item_t;

    // Per-item control that rides alongside the sample memory read
    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic [LEVEL_W-1:0]    level;
        logic [PHASE_BITS-1:0] frac;
    } rd_ctl_t;

    function automatic int mem_depth(input int num_tables, input int max_frames,
                                     input int max_frame_size);
        return num_tables * 2 * max_frames * max_frame_size;
    endfunction

    function automatic int addr_width(input int num_tables, input int max_frames,
                                      input int max_frame_size);
        return $clog2(mem_depth(num_tables, max_frames, max_frame_size));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mwsr_sample_mem.sv =====
// Sample word memory: one write port, two registered read ports.
`default_nettype none

module mwsr_sample_mem
    import mwsr_pkg::*;
#(
    parameter int NUM_TABLES     = DEF_NUM_TABLES,
    parameter int MAX_FRAMES     = DEF_MAX_FRAMES,
    parameter int MAX_FRAME_SIZE = DEF_MAX_FRAME_SIZE
) (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire logic                wr_en,
    input  wire logic [addr_width(NUM_TABLES, MAX_FRAMES, MAX_FRAME_SIZE)-1:0] wr_addr,
    input  wire logic [SAMPLE_W-1:0] wr_data,
    input  wire logic [addr_width(NUM_TABLES, MAX_FRAMES, MAX_FRAME_SIZE)-1:0] rd_addr0,
    input  wire logic [addr_width(NUM_TABLES, MAX_FRAMES, MAX_FRAME_SIZE)-1:0] rd_addr1,
    output logic      [SAMPLE_W-1:0] rd_data0,
    output logic      [SAMPLE_W-1:0] rd_data1
);

    localparam int DEPTH = mem_depth(NUM_TABLES, MAX_FRAMES, MAX_FRAME_SIZE);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd0_reg;
    logic [SAMPLE_W-1:0] rd1_reg;

    // Hold read data while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            if (wr_en) begin
                mem[wr_addr] <= wr_data;
            end
            rd0_reg <= mem[rd_addr0];
            rd1_reg <= mem[rd_addr1];
        end
    end

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;

endmodule

`default_nettype wire

// ===== rtl/mwsr_front.sv =====
// Front end: descriptor store, mip level choice and sample address generation.
`default_nettype none

module mwsr_front
    import mwsr_pkg::*;
#(
    parameter int NUM_TABLES     = DEF_NUM_TABLES,
    parameter int MAX_FRAMES     = DEF_MAX_FRAMES,
    parameter int MAX_FRAME_SIZE = DEF_MAX_FRAME_SIZE,
    parameter int MIN_MIP_SIZE   = DEF_MIN_MIP_SIZE
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                adv,
    input  wire logic                in_valid,
    input  wire item_t               in_item,
    output logic                     wr_en,
    output logic [addr_width(NUM_TABLES, MAX_FRAMES, MAX_FRAME_SIZE)-1:0] wr_addr,
    output logic [SAMPLE_W-1:0]      wr_data,
    output logic [addr_width(NUM_TABLES, MAX_FRAMES, MAX_FRAME_SIZE)-1:0] rd_addr0,
    output logic [addr_width(NUM_TABLES, MAX_FRAMES, MAX_FRAME_SIZE)-1:0] rd_addr1,
    output rd_ctl_t                  ctl
);

    localparam int MFS_LOG    = $clog2(MAX_FRAME_SIZE);
    localparam int MIN_LOG    = $clog2(MIN_MIP_SIZE);
    localparam int TOP_LEVEL  = MFS_LOG - MIN_LOG;
    localparam int FR_W       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int TBL_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int IDX_W      = MFS_LOG;
    localparam int ADDR_W     = addr_width(NUM_TABLES, MAX_FRAMES, MAX_FRAME_SIZE);
    localparam int TABLE_SPAN = 2 * MAX_FRAMES * MAX_FRAME_SIZE;

    // Start of frame f of level lvl in table t; one extra bit keeps the span exact
    function automatic logic [ADDR_W-1:0] row_base(input logic [TIDX_W-1:0]  t,
                                                   input logic [LEVEL_W-1:0] lvl,
                                                   input logic [FR_W-1:0]    f);
        logic [ADDR_W:0] span;
        logic [ADDR_W:0] sum;
        span = (ADDR_W + 1)'(TABLE_SPAN);
        sum  = (ADDR_W + 1)'(t) * span + span - (span >> lvl)
             + ((ADDR_W + 1)'(f) << (MFS_LOG - int'(lvl)));
        return sum[ADDR_W-1:0];
    endfunction

    // Descriptor store
    logic [FCNT_W-1:0] frames_reg [NUM_TABLES];
    logic [FLOG_W-1:0] slog_reg   [NUM_TABLES];

    // Stage 1
    logic  s1_valid_reg;
    item_t s1_item_reg;

    logic                     t_ok;
    logic [TBL_W-1:0]         t_sel;
    logic [FCNT_W-1:0]        cur_frames;
    logic [FLOG_W-1:0]        cur_slog;
    logic                     is_wr;
    logic                     is_desc;
    logic                     is_rd;
    logic                     desc_ok;
    logic                     wr_ok;
    logic [FR_W-1:0]          frame_w;
    logic signed [FRAME_W-1:0] frame_max;
    logic [FR_W-1:0]          frame_c;
    logic [INC_W-1:0]         inc_m1;
    logic [EXP_W-1:0]         inc_exp;
    logic [ADDR_W-1:0]        wr_addr_c;

    // Stage 2
    logic                  s2_valid_reg;
    logic                  s2_wr_reg;
    logic                  s2_hit_reg;
    logic [ADDR_W-1:0]     s2_wr_addr_reg;
    logic [SAMPLE_W-1:0]   s2_wr_data_reg;
    logic [TIDX_W-1:0]     s2_t_reg;
    logic [FLOG_W-1:0]     s2_slog_reg;
    logic [EXP_W-1:0]      s2_exp_reg;
    logic [FR_W-1:0]       s2_frame_reg;
    logic [PHASE_BITS-1:0] s2_phase_reg;

    logic signed [7:0]              sel_raw;
    logic [LEVEL_W-1:0]             sel_max;
    logic [LEVEL_W-1:0]             sel;
    logic [LEVEL_W-1:0]             lg;
    logic [IDX_W+PHASE_BITS-1:0]    scaled;
    logic [IDX_W-1:0]               i0;
    logic [IDX_W-1:0]               i1;
    logic [IDX_W-1:0]               idx_mask;
    logic [ADDR_W-1:0]              rd_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg <= in_item;
        end
    end

    always_comb begin
        t_ok       = 32'(s1_item_reg.table_index) < NUM_TABLES;
        t_sel      = TBL_W'(s1_item_reg.table_index);
        cur_frames = t_ok ? frames_reg[t_sel] : '0;
        cur_slog   = t_ok ? slog_reg[t_sel] : '0;

        is_wr   = 1'b0;
        is_desc = 1'b0;
        is_rd   = 1'b0;
        unique case (s1_item_reg.func)
            FUNC_WR_SAMPLE: is_wr   = 1'b1;
            FUNC_WR_DESC:   is_desc = 1'b1;
            FUNC_READ:      is_rd   = 1'b1;
            default: ;
        endcase

        desc_ok = (s1_item_reg.frame_count != '0)
                && (32'(s1_item_reg.frame_count) <= MAX_FRAMES)
                && (32'(s1_item_reg.frame_size_log2) >= MIN_LOG)
                && (32'(s1_item_reg.frame_size_log2) <= MFS_LOG);

        wr_ok = t_ok
              && (32'(s1_item_reg.level) <= TOP_LEVEL)
              && !s1_item_reg.frame[FRAME_W-1]
              && (32'(s1_item_reg.frame) < MAX_FRAMES)
              && (32'(s1_item_reg.sample_index) < (32'(MAX_FRAME_SIZE) >> s1_item_reg.level));
        frame_w   = FR_W'(s1_item_reg.frame);
        wr_addr_c = row_base(s1_item_reg.table_index, s1_item_reg.level, frame_w)
                  + ADDR_W'(s1_item_reg.sample_index);

        // Clamp the read frame into 0..frames-1
        frame_max = FRAME_W'(cur_frames) - FRAME_W'(1);
        if (s1_item_reg.frame[FRAME_W-1]) begin
            frame_c = '0;
        end else if (s1_item_reg.frame > frame_max) begin
            frame_c = FR_W'(frame_max);
        end else begin
            frame_c = FR_W'(s1_item_reg.frame);
        end

        // Smallest e with increment <= 2^e
        inc_m1  = s1_item_reg.phase_increment - INC_W'(1);
        inc_exp = '0;
        for (int i = 0; i < INC_W; i++) begin
            if (inc_m1[i]) begin
                inc_exp = EXP_W'(i + 1);
            end
        end
        if (s1_item_reg.phase_increment == '0) begin
            inc_exp = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TABLES; i++) begin
                frames_reg[i] <= '0;
                slog_reg[i]   <= '0;
            end
        end else if (adv && s1_valid_reg && is_desc && t_ok) begin
            frames_reg[t_sel] <= desc_ok ? s1_item_reg.frame_count : '0;
            slog_reg[t_sel]   <= s1_item_reg.frame_size_log2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s2_wr_reg    <= 1'b0;
            s2_hit_reg   <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
            s2_wr_reg    <= s1_valid_reg && is_wr && wr_ok;
            s2_hit_reg   <= s1_valid_reg && is_rd && t_ok && (cur_frames != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_wr_addr_reg <= wr_addr_c;
            s2_wr_data_reg <= s1_item_reg.sample_value;
            s2_t_reg       <= s1_item_reg.table_index;
            s2_slog_reg    <= cur_slog;
            s2_exp_reg     <= inc_exp;
            s2_frame_reg   <= frame_c;
            s2_phase_reg   <= s1_item_reg.phase;
        end
    end

    // Level: first L whose half size times the increment stays within half a cycle
    always_comb begin
        sel_raw = 8'(s2_exp_reg) + 8'(s2_slog_reg) - 8'(PHASE_BITS);
        sel_max = LEVEL_W'(s2_slog_reg) - LEVEL_W'(MIN_LOG);
        if (sel_raw < 0) begin
            sel = '0;
        end else if (sel_raw > $signed(8'(sel_max))) begin
            sel = sel_max;
        end else begin
            sel = LEVEL_W'(sel_raw);
        end

        lg       = LEVEL_W'(s2_slog_reg) - sel;
        scaled   = {{IDX_W{1'b0}}, s2_phase_reg} << lg;
        i0       = scaled[IDX_W+PHASE_BITS-1:PHASE_BITS];
        idx_mask = ~({IDX_W{1'b1}} << lg);
        i1       = (i0 + IDX_W'(1)) & idx_mask;
        rd_base  = row_base(s2_t_reg, sel, s2_frame_reg);
    end

    assign wr_en     = s2_valid_reg && s2_wr_reg;
    assign wr_addr   = s2_wr_addr_reg;
    assign wr_data   = s2_wr_data_reg;
    assign rd_addr0  = rd_base + ADDR_W'(i0);
    assign rd_addr1  = rd_base + ADDR_W'(i1);
    assign ctl.valid = s2_valid_reg;
    assign ctl.hit   = s2_valid_reg && s2_hit_reg;
    assign ctl.level = s2_hit_reg ? sel : '0;
    assign ctl.frac  = scaled[PHASE_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/mwsr_interp.sv =====
// Linear interpolation between the two neighbor samples and the result register.
`default_nettype none

module mwsr_interp
    import mwsr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                adv,
    input  wire rd_ctl_t             ctl_in,
    input  wire logic [SAMPLE_W-1:0] rd_data0,
    input  wire logic [SAMPLE_W-1:0] rd_data1,
    output logic                     out_valid,
    output logic [SAMPLE_W-1:0]      out_sample,
    output logic [LEVEL_W-1:0]       out_level,
    output logic                     out_hit
);

    localparam int PROD_W = SAMPLE_W + PHASE_BITS + 2;

    rd_ctl_t c3_reg;
    rd_ctl_t c4_reg;

    logic signed [SAMPLE_W:0]    diff;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    p4_reg;
    logic [SAMPLE_W-1:0]         s0_4_reg;
    logic signed [SAMPLE_W+1:0]  step;
    logic signed [SAMPLE_W+1:0]  total;

    logic                  out_valid_reg;
    logic [SAMPLE_W-1:0]   out_sample_reg;
    logic [LEVEL_W-1:0]    out_level_reg;
    logic                  out_hit_reg;

    // Align control with the memory read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c3_reg.valid <= 1'b0;
            c4_reg.valid <= 1'b0;
        end else if (adv) begin
            c3_reg <= ctl_in;
            c4_reg <= c3_reg;
        end
    end

    always_comb begin
        diff = $signed({rd_data1[SAMPLE_W-1], rd_data1})
             - $signed({rd_data0[SAMPLE_W-1], rd_data0});
        prod = diff * $signed({1'b0, c3_reg.frac});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_reg   <= prod;
            s0_4_reg <= rd_data0;
        end
    end

    // Floor shift of the weighted difference, then add the base sample
    always_comb begin
        step  = p4_reg[PROD_W-1:PHASE_BITS];
        total = $signed({{2{s0_4_reg[SAMPLE_W-1]}}, s0_4_reg}) + step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= c4_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_sample_reg <= c4_reg.hit ? total[SAMPLE_W-1:0] : '0;
            out_level_reg  <= c4_reg.hit ? c4_reg.level : '0;
            out_hit_reg    <= c4_reg.hit;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_level  = out_level_reg;
    assign out_hit    = out_hit_reg;

endmodule

`default_nettype wire

// ===== rtl/mipmapped_wavetable_sample_reader_unit.sv =====
// Top level of the mipmapped wavetable sample reader.
//
//  Channel  Direction  Handshake                      Carries
//  s_axis   in         s_axis_tvalid / s_axis_tready  write sample, write descriptor or read
//  m_axis   out        m_axis_tvalid / m_axis_tready  one result per input transaction
//
// One transaction is taken per clock unless a result is held back, and
// each yields a result on m_axis. The five register stages are the input
// register, the address stage, the sample memory's registered read (both
// neighbors read together through two ports), the product register behind
// the interpolation multiplier and the output register.
// Reset clears the descriptor registers; the sample memory has no clearing
// pass and holds nothing defined until written.
// Low m_axis_tready with a result waiting freezes every stage and drops
// s_axis_tready in the same cycle.
`default_nettype none

module mipmapped_wavetable_sample_reader_unit
    import mwsr_pkg::*;
#(
    parameter int NUM_TABLES     = DEF_NUM_TABLES,
    parameter int MAX_FRAMES     = DEF_MAX_FRAMES,
    parameter int MAX_FRAME_SIZE = DEF_MAX_FRAME_SIZE,
    parameter int MIN_MIP_SIZE   = DEF_MIN_MIP_SIZE
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // table_index, level, frame, sample_index, sample_value, frame_count,
    // frame_size_log2, phase, phase_increment, zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // func
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // sample, level_used, zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // read_valid
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser
);

    localparam int ADDR_W = addr_width(NUM_TABLES, MAX_FRAMES, MAX_FRAME_SIZE);

    logic    adv;
    item_t   in_item;
    logic    wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic [ADDR_W-1:0]   rd_addr0;
    logic [ADDR_W-1:0]   rd_addr1;
    logic [SAMPLE_W-1:0] rd_data0;
    logic [SAMPLE_W-1:0] rd_data1;
    rd_ctl_t             ctl;
    logic                out_valid;
    logic [SAMPLE_W-1:0] out_sample;
    logic [LEVEL_W-1:0]  out_level;
    logic                out_hit;

    // Whole pipeline advances unless a finished result is held back
    assign adv           = !out_valid || m_axis_tready;
    assign s_axis_tready = adv;

    // Unpack the input transaction, lowest field first
    assign in_item.func            = func_t'(s_axis_tuser);
    assign in_item.table_index     = s_axis_tdata[1:0];
    assign in_item.level           = s_axis_tdata[5:2];
    assign in_item.frame           = s_axis_tdata[17:6];
    assign in_item.sample_index    = s_axis_tdata[28:18];
    assign in_item.sample_value    = s_axis_tdata[44:29];
    assign in_item.frame_count     = s_axis_tdata[51:45];
    assign in_item.frame_size_log2 = s_axis_tdata[55:52];
    assign in_item.phase           = s_axis_tdata[79:56];
    assign in_item.phase_increment = s_axis_tdata[104:80];

    mwsr_front #(
        .NUM_TABLES     (NUM_TABLES),
        .MAX_FRAMES     (MAX_FRAMES),
        .MAX_FRAME_SIZE (MAX_FRAME_SIZE),
        .MIN_MIP_SIZE   (MIN_MIP_SIZE)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_axis_tvalid),
        .in_item  (in_item),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .ctl      (ctl)
    );

    mwsr_sample_mem #(
        .NUM_TABLES     (NUM_TABLES),
        .MAX_FRAMES     (MAX_FRAMES),
        .MAX_FRAME_SIZE (MAX_FRAME_SIZE)
    ) u_mem (
        .aclk     (aclk),
        .en       (adv),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    mwsr_interp u_interp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .ctl_in     (ctl),
        .rd_data0   (rd_data0),
        .rd_data1   (rd_data1),
        .out_valid  (out_valid),
        .out_sample (out_sample),
        .out_level  (out_level),
        .out_hit    (out_hit)
    );

    // Pack the result transaction, lowest field first
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({out_level, out_sample});
    assign m_axis_tuser  = OUT_TUSER_W'(out_hit);

endmodule

`default_nettype wire

// ===== rtl/mwsr_checker.sv =====
// Port-level checks of the wavetable sample reader, bound to the top level.
`default_nettype none

module mwsr_checker
    import mwsr_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // A held result stalls the input side in the same cycle
    a_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while result is stalled");

    // With no result pending the input side is open
    a_in_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // Writes and missed reads return all zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("nonzero result without a valid read");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind mipmapped_wavetable_sample_reader_unit mwsr_checker u_checker (.*);

`default_nettype wire
